// ----- rtl/core/scipcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scipcs_pkg: shared definitions for the block checksum stripper
// Constants, configuration codes and the types passed between the stages.
// ----------------------------------------------------------------------------
package scipcs_pkg;

  localparam int unsigned DATA_PER_BLOCK_DEF  = 64;
  localparam int unsigned MAX_FRAME_BYTES_DEF = 8191;

  localparam int unsigned FRAME_LEN_W = 13;
  localparam int unsigned MASK_W      = 8;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_MASK = 1'b1;

  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = '0;
  localparam logic [MASK_W-1:0]      MASK_RESET      = 8'h3F;

  localparam logic [7:0] CHECK_BASE = 8'h30;
  localparam logic [7:0] LINE_FEED  = 8'h0A;

  typedef struct packed {
    logic [FRAME_LEN_W-1:0] frame_length;
    logic [MASK_W-1:0]      checksum_mask;
  } cfg_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       checksum_error;
    logic       linefeed_error;
    logic       frame_end;
  } res_t;

  typedef struct packed {
    logic idle;
    logic in_final;
  } status_t;

endpackage

// ----- rtl/core/scipcs_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scipcs_in_stage: input word register
// Captures one raw word and holds it until the result stage takes it.
// ----------------------------------------------------------------------------
module scipcs_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] raw_byte_i,
  input  logic       advance_i,
  output logic       s1_valid_o,
  output logic [7:0] s1_byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;
  assign s1_valid_o = valid_q;
  assign s1_byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= raw_byte_i;
    end
  end

endmodule

// ----- rtl/core/scipcs_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scipcs_deframer: frame and block sequencer
// Tracks frame and block position, sums data words, checks each block's checksum
// and each full block's line feed; state advances on every word handed to the result.
// ----------------------------------------------------------------------------
module scipcs_deframer #(
  parameter int unsigned DATA_PER_BLOCK  = scipcs_pkg::DATA_PER_BLOCK_DEF,
  parameter int unsigned MAX_FRAME_BYTES = scipcs_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scipcs_pkg::cfg_t     cfg_i,
  input  logic [7:0]           byte_i,
  input  logic                 fire_i,
  output scipcs_pkg::res_t     res_o,
  output scipcs_pkg::status_t  status_o
);

  localparam int unsigned LEFT_W     = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned POS_W      = $clog2(DATA_PER_BLOCK + 4);
  localparam int unsigned CMP_W      = (LEFT_W > scipcs_pkg::FRAME_LEN_W) ?
                                       LEFT_W : scipcs_pkg::FRAME_LEN_W;
  localparam int unsigned FINAL_MAX  = DATA_PER_BLOCK + 3;

  logic [LEFT_W-1:0] left_q, left_d, left_w, len_w;
  logic [POS_W-1:0]  pos_q, pos_d, pos_w, fsize_q, fsize_d, fsize_w;
  logic              infin_q, infin_d, infin_w;
  logic [7:0]        sum_q, sum_d, sum_w;
  logic              cflag_q, cflag_d, cflag_w;
  logic              lflag_q, lflag_d, lflag_w;
  logic [CMP_W-1:0]  fl_ext, max_ext;
  logic              idle, match, fend, dvalid;
  logic [7:0]        dbyte;

  assign idle    = (left_q == '0);
  assign fl_ext  = CMP_W'(cfg_i.frame_length);
  assign max_ext = CMP_W'(MAX_FRAME_BYTES);
  assign len_w   = LEFT_W'((fl_ext > max_ext) ? max_ext : fl_ext);

  always_comb begin
    left_w  = idle ? len_w : left_q;
    pos_w   = idle ? '0 : pos_q;
    fsize_w = idle ? '0 : fsize_q;
    infin_w = idle ? 1'b0 : infin_q;
    sum_w   = idle ? '0 : sum_q;
    cflag_w = idle ? 1'b0 : cflag_q;
    lflag_w = idle ? 1'b0 : lflag_q;
    left_d  = left_q;
    pos_d   = pos_q;
    fsize_d = fsize_q;
    infin_d = infin_q;
    sum_d   = sum_q;
    cflag_d = cflag_q;
    lflag_d = lflag_q;
    dvalid  = 1'b0;
    dbyte   = '0;
    fend    = 1'b0;
    match   = 1'b0;
    if (!(idle && len_w == '0)) begin
      if (!infin_w && pos_w == '0 && left_w <= LEFT_W'(FINAL_MAX)) begin
        infin_w = 1'b1;
        fsize_w = POS_W'(left_w);
      end
      pos_d   = pos_w;
      sum_d   = sum_w;
      cflag_d = cflag_w;
      lflag_d = lflag_w;
      infin_d = infin_w;
      fsize_d = fsize_w;
      match   = ({1'b0, sum_w & cfg_i.checksum_mask} + {1'b0, scipcs_pkg::CHECK_BASE})
                == {1'b0, byte_i};
      if (!infin_w) begin
        if (pos_w < POS_W'(DATA_PER_BLOCK)) begin
          dvalid = 1'b1;
          dbyte  = byte_i;
          sum_d  = sum_w + byte_i;
          pos_d  = pos_w + 1'b1;
        end else if (pos_w == POS_W'(DATA_PER_BLOCK)) begin
          if (!match) cflag_d = 1'b1;
          pos_d = pos_w + 1'b1;
        end else begin
          if (byte_i != scipcs_pkg::LINE_FEED) lflag_d = 1'b1;
          pos_d = '0;
          sum_d = '0;
        end
      end else begin
        if (fsize_w < POS_W'(3)) begin
          if (pos_w == '0) cflag_d = 1'b1;
        end else if (pos_w < fsize_w - POS_W'(2)) begin
          dvalid = 1'b1;
          dbyte  = byte_i;
          sum_d  = sum_w + byte_i;
        end else if (pos_w == fsize_w - POS_W'(2)) begin
          if (!match) cflag_d = 1'b1;
        end
        pos_d = pos_w + 1'b1;
      end
      left_d = left_w - 1'b1;
      if (left_d == '0) begin
        fend    = 1'b1;
        infin_d = 1'b0;
        fsize_d = '0;
        pos_d   = '0;
        sum_d   = '0;
      end
    end
  end

  assign res_o.data_valid     = dvalid;
  assign res_o.data_byte      = dbyte;
  assign res_o.checksum_error = cflag_d;
  assign res_o.linefeed_error = lflag_d;
  assign res_o.frame_end      = fend;

  assign status_o.idle     = idle;
  assign status_o.in_final = infin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      pos_q   <= '0;
      fsize_q <= '0;
      infin_q <= 1'b0;
      sum_q   <= '0;
      cflag_q <= 1'b0;
      lflag_q <= 1'b0;
    end else if (fire_i) begin
      left_q  <= left_d;
      pos_q   <= pos_d;
      fsize_q <= fsize_d;
      infin_q <= infin_d;
      sum_q   <= sum_d;
      cflag_q <= cflag_d;
      lflag_q <= lflag_d;
    end
  end

endmodule

// ----- rtl/core/scip_block_checksum_stripper.sv -----
// Path: an accepted word goes through the input register, then the result register.
// Throughput: one word per cycle while the output is ready; an output stall
// holds the input in the same cycle once the input register is full.
// Reset: asynchronous, active low; frame_length reads 0, checksum_mask 0x3F,
// frame state returns to idle at once with no clearing pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scip_block_checksum_stripper: range-data block checksum stripper
// Removes per-block checksums and line feeds from a frame, passes data words
// on and reports sticky checksum and line feed errors.
// ----------------------------------------------------------------------------
module scip_block_checksum_stripper #(
  parameter int unsigned DATA_PER_BLOCK  = scipcs_pkg::DATA_PER_BLOCK_DEF,
  parameter int unsigned MAX_FRAME_BYTES = scipcs_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [scipcs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [scipcs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       raw_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             data_valid_o,
  output logic [7:0]                       data_byte_o,
  output logic                             checksum_error_o,
  output logic                             linefeed_error_o,
  output logic                             frame_end_o
);

  scipcs_pkg::cfg_t    cfg_q;
  scipcs_pkg::res_t    res, res_q;
  scipcs_pkg::status_t status;
  logic                out_valid_q, out_valid_d;
  logic                advance, fire, s1_valid;
  logic [7:0]          s1_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_length  <= scipcs_pkg::FRAME_LEN_RESET;
      cfg_q.checksum_mask <= scipcs_pkg::MASK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        scipcs_pkg::CFG_FRAME_LENGTH: begin
          cfg_q.frame_length <= cfg_wdata_i[scipcs_pkg::FRAME_LEN_W-1:0];
        end
        scipcs_pkg::CFG_CHECKSUM_MASK: begin
          cfg_q.checksum_mask <= cfg_wdata_i[scipcs_pkg::MASK_W-1:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  assign advance     = !out_valid_q || out_ready_i;
  assign fire        = s1_valid && advance;
  assign out_valid_d = advance ? s1_valid : out_valid_q;

  scipcs_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .raw_byte_i (raw_byte_i),
    .advance_i  (advance),
    .s1_valid_o (s1_valid),
    .s1_byte_o  (s1_byte)
  );

  scipcs_deframer #(
    .DATA_PER_BLOCK  (DATA_PER_BLOCK),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_deframer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .byte_i   (s1_byte),
    .fire_i   (fire),
    .res_o    (res),
    .status_o (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_valid_o     = res_q.data_valid;
  assign data_byte_o      = res_q.data_byte;
  assign checksum_error_o = res_q.checksum_error;
  assign linefeed_error_o = res_q.linefeed_error;
  assign frame_end_o      = res_q.frame_end;

`ifndef ASSERT_OFF
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without an output stall");

  a_frame_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res.frame_end) |=> status.idle)
    else $error("frame state not idle after frame end");

  a_idle_not_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.idle |-> !status.in_final)
    else $error("final block marked while idle");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !advance) |=> s1_valid)
    else $error("input word lost during output stall");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: block checksum stripper
// Feeds raw range-data frames through the stripper under changing frame
// length and checksum mask settings. A directed table covers reset values,
// ignored words, short final blocks, the unchecked final line feed and the
// 9-bit checksum compare. Random frames with mostly valid checksums and line
// feeds follow under three idle profiles and receiver hold-offs. Every
// output word is checked against a predictor or the table's expected word.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned FULL_BLOCK      = scipcs_pkg::DATA_PER_BLOCK_DEF + 2;
  localparam int unsigned LIMIT_CYCLES    = 500000;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned WORDS_PER_PHASE = 400;
  localparam int unsigned NUM_DIR         = 23;
  localparam int unsigned IDX_W           = scipcs_pkg::CFG_IDX_W;
  localparam int unsigned DATA_W          = scipcs_pkg::CFG_DATA_W;

  localparam logic [IDX_W-1:0] IDX_LEN  = scipcs_pkg::CFG_FRAME_LENGTH;
  localparam logic [IDX_W-1:0] IDX_MASK = scipcs_pkg::CFG_CHECKSUM_MASK;

  typedef enum logic [1:0] {ROW_WRITE, ROW_WORD, ROW_WORD_KNOWN} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [IDX_W-1:0]   idx;
    logic [DATA_W-1:0]  value;
    scipcs_pkg::res_t   want;
  } dir_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [IDX_W-1:0]      cfg_idx_i   = '0;
  logic [DATA_W-1:0]     cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            raw_byte_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  data_valid_o;
  logic [7:0]            data_byte_o;
  logic                  checksum_error_o;
  logic                  linefeed_error_o;
  logic                  frame_end_o;

  // predictor state and register copies
  logic [scipcs_pkg::FRAME_LEN_W-1:0] frame_len_q = scipcs_pkg::FRAME_LEN_RESET;
  logic [scipcs_pkg::MASK_W-1:0]      mask_q      = scipcs_pkg::MASK_RESET;
  logic [12:0]            frm_left    = '0;
  logic [6:0]             blk_pos     = '0;
  logic [6:0]             tail_size   = '0;
  logic                   in_tail     = 1'b0;
  logic [7:0]             blk_sum     = '0;
  logic                   cs_sticky   = 1'b0;
  logic                   lf_sticky   = 1'b0;

  scipcs_pkg::res_t stripped_q[$];
  scipcs_pkg::res_t mon_word;
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned hold_reqs     = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned fail_cnt      = 0;
  int unsigned checked_cnt   = 0;
  int unsigned frame_words   = 0;
  int unsigned frame_cnt     = 0;
  int unsigned reg_writes    = 0;
  int unsigned cycle_cnt     = 0;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{ROW_WORD_KNOWN, IDX_LEN,  13'h0FF, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_WORD_KNOWN, IDX_LEN,  13'h000, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_WRITE,      IDX_LEN,  13'd1,   '0},
    '{ROW_WORD_KNOWN, IDX_LEN,  13'h041, '{1'b0, 8'h00, 1'b1, 1'b0, 1'b1}},
    '{ROW_WRITE,      IDX_LEN,  13'd2,   '0},
    '{ROW_WORD_KNOWN, IDX_LEN,  13'h000, '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0}},
    '{ROW_WORD_KNOWN, IDX_LEN,  13'h0FF, '{1'b0, 8'h00, 1'b1, 1'b0, 1'b1}},
    '{ROW_WRITE,      IDX_LEN,  13'd0,   '0},
    '{ROW_WORD_KNOWN, IDX_LEN,  13'h05A, '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0}},
    '{ROW_WRITE,      IDX_LEN,  13'd3,   '0},
    '{ROW_WORD_KNOWN, IDX_LEN,  13'h0FF, '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0}},
    '{ROW_WORD_KNOWN, IDX_LEN,  13'h06F, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_WORD_KNOWN, IDX_LEN,  13'h000, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1}},
    '{ROW_WRITE,      IDX_MASK, 13'h0FF, '0},
    '{ROW_WORD_KNOWN, IDX_LEN,  13'h0FF, '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0}},
    '{ROW_WORD_KNOWN, IDX_LEN,  13'h02F, '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0}},
    '{ROW_WORD_KNOWN, IDX_LEN,  13'h0FF, '{1'b0, 8'h00, 1'b1, 1'b0, 1'b1}},
    '{ROW_WRITE,      IDX_MASK, 13'h000, '0},
    '{ROW_WRITE,      IDX_LEN,  13'd4,   '0},
    '{ROW_WORD,       IDX_LEN,  13'h080, '0},
    '{ROW_WORD,       IDX_LEN,  13'h07F, '0},
    '{ROW_WORD,       IDX_LEN,  13'h030, '0},
    '{ROW_WORD,       IDX_LEN,  13'h00A, '0}
  };

  scip_block_checksum_stripper i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .raw_byte_i       (raw_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .data_valid_o     (data_valid_o),
    .data_byte_o      (data_byte_o),
    .checksum_error_o (checksum_error_o),
    .linefeed_error_o (linefeed_error_o),
    .frame_end_o      (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit sum_ok(input logic [7:0] b);
    logic [8:0] want9;
    want9 = {1'b0, blk_sum & mask_q} + {1'b0, scipcs_pkg::CHECK_BASE};
    return want9 == {1'b0, b};
  endfunction

  function automatic scipcs_pkg::res_t strip_byte(input logic [7:0] b);
    scipcs_pkg::res_t r;
    int unsigned      len;
    r = '0;
    if (frm_left == 0) begin
      len = frame_len_q;
      if (len > scipcs_pkg::MAX_FRAME_BYTES_DEF) len = scipcs_pkg::MAX_FRAME_BYTES_DEF;
      if (len == 0) begin
        r.checksum_error = cs_sticky;
        r.linefeed_error = lf_sticky;
        return r;
      end
      frm_left  = len[12:0];
      cs_sticky = 1'b0;
      lf_sticky = 1'b0;
      in_tail   = 1'b0;
      tail_size = '0;
      blk_pos   = '0;
      blk_sum   = '0;
    end
    if (!in_tail && blk_pos == 0 && frm_left <= FULL_BLOCK + 1) begin
      in_tail   = 1'b1;
      tail_size = frm_left[6:0];
    end
    if (!in_tail) begin
      if (blk_pos < scipcs_pkg::DATA_PER_BLOCK_DEF) begin
        r.data_valid = 1'b1;
        r.data_byte  = b;
        blk_sum      = blk_sum + b;
        blk_pos      = blk_pos + 7'd1;
      end else if (blk_pos == scipcs_pkg::DATA_PER_BLOCK_DEF) begin
        if (!sum_ok(b)) cs_sticky = 1'b1;
        blk_pos = blk_pos + 7'd1;
      end else begin
        if (b != scipcs_pkg::LINE_FEED) lf_sticky = 1'b1;
        blk_pos = '0;
        blk_sum = '0;
      end
    end else begin
      if (tail_size < 3) begin
        if (blk_pos == 0) cs_sticky = 1'b1;
      end else if (blk_pos < tail_size - 7'd2) begin
        r.data_valid = 1'b1;
        r.data_byte  = b;
        blk_sum      = blk_sum + b;
      end else if (blk_pos == tail_size - 7'd2) begin
        if (!sum_ok(b)) cs_sticky = 1'b1;
      end
      blk_pos = blk_pos + 7'd1;
    end
    frm_left = frm_left - 13'd1;
    if (frm_left == 0) begin
      r.frame_end = 1'b1;
      in_tail     = 1'b0;
      tail_size   = '0;
      blk_pos     = '0;
      blk_sum     = '0;
    end
    r.checksum_error = cs_sticky;
    r.linefeed_error = lf_sticky;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_len();
    case ($urandom_range(9))
      0:       return DATA_W'($urandom_range(3, 1));
      1:       return DATA_W'($urandom_range(70, 66));
      2:       return DATA_W'($urandom_range(136, 130));
      3:       return '0;
      default: return DATA_W'($urandom_range(140, 4));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_mask();
    logic [DATA_W-1:0] v;
    v = DATA_W'($urandom);
    case ($urandom_range(5))
      0:       v[scipcs_pkg::MASK_W-1:0] = 8'h00;
      1:       v[scipcs_pkg::MASK_W-1:0] = 8'hFF;
      2:       v[scipcs_pkg::MASK_W-1:0] = scipcs_pkg::MASK_RESET;
      default: v[scipcs_pkg::MASK_W-1:0] = 8'($urandom_range(255));
    endcase
    return v;
  endfunction

  task automatic cmp_field(input string name, input int unsigned exp_v,
                           input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      fail_cnt++;
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input bit known,
                           input scipcs_pkg::res_t known_word);
    scipcs_pkg::res_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    r = strip_byte(b);
    stripped_q.push_back(known ? known_word : r);
  endtask

  task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (stripped_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == IDX_LEN) frame_len_q = value[scipcs_pkg::FRAME_LEN_W-1:0];
    else mask_q = value[scipcs_pkg::MASK_W-1:0];
    reg_writes++;
  endtask

  task automatic send_frame(input int unsigned len);
    logic [7:0]       fb[$];
    logic [7:0]       sum;
    logic [7:0]       cs;
    logic [7:0]       lf;
    logic [7:0]       d;
    logic [IDX_W-1:0] widx;
    int unsigned      remain;
    int unsigned      n;
    int               split;
    bit               noise;
    bit               is_tail;
    noise  = ($urandom_range(11) == 0);
    remain = len;
    while (remain > 0) begin
      if (remain < 3) begin
        repeat (remain) fb.push_back(8'($urandom_range(255)));
        remain = 0;
      end else begin
        is_tail = (remain <= FULL_BLOCK + 1);
        n       = is_tail ? remain - 2 : scipcs_pkg::DATA_PER_BLOCK_DEF;
        sum     = '0;
        repeat (n) begin
          d   = 8'($urandom_range(255));
          sum = sum + d;
          fb.push_back(d);
        end
        cs = (sum & mask_q) + scipcs_pkg::CHECK_BASE;
        if ($urandom_range(99) < 8) cs = 8'($urandom_range(255));
        lf = scipcs_pkg::LINE_FEED;
        if ($urandom_range(99) < (is_tail ? 40 : 8)) lf = 8'($urandom_range(255));
        fb.push_back(cs);
        fb.push_back(lf);
        remain = remain - n - 2;
      end
    end
    if (noise) foreach (fb[i]) fb[i] = 8'($urandom_range(255));
    split = (len > 1 && $urandom_range(19) == 0) ? int'($urandom_range(len - 1, 1)) : -1;
    foreach (fb[i]) begin
      if (i == split) begin
        widx = IDX_W'($urandom_range(1));
        set_reg(widx, (widx == IDX_LEN) ? pick_len() : pick_mask());
      end
      push_byte(fb[i], 1'b0, '0);
      frame_words++;
    end
    frame_cnt++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (stripped_q.size() == 0) begin
        $error("output word with none expected");
        fail_cnt++;
      end else begin
        mon_word = stripped_q.pop_front();
        cmp_field("data_valid", mon_word.data_valid, data_valid_o);
        cmp_field("data_byte", mon_word.data_byte, data_byte_o);
        cmp_field("checksum_error", mon_word.checksum_error, checksum_error_o);
        cmp_field("linefeed_error", mon_word.linefeed_error, linefeed_error_o);
        cmp_field("frame_end", mon_word.frame_end, frame_end_o);
        checked_cnt++;
      end
    end
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int ph;
    int unsigned goal;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle_pct  = 22;
    sink_idle_pct = 71;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        set_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        push_byte(dir_rows[i].value[7:0], dir_rows[i].kind == ROW_WORD_KNOWN,
                  dir_rows[i].want);
      end
    end
    for (ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 22 : (ph == 1) ? 71 : 0;
      sink_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 22 : 0;
      goal          = frame_words + WORDS_PER_PHASE;
      // hold the output while a long frame keeps coming
      set_reg(IDX_LEN, 13'd150);
      hold_reqs++;
      send_frame(frame_len_q);
      while (frame_words < goal) begin
        set_reg(IDX_LEN, pick_len());
        set_reg(IDX_MASK, pick_mask());
        if (frame_len_q == 0) begin
          repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255)), 1'b0, '0);
        end else begin
          repeat ($urandom_range(3, 1)) send_frame(frame_len_q);
        end
      end
    end
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (stripped_q.size() != 0);
    repeat (10) @(posedge clk_i);
    $display("Checked %0d output words: %0d frames, %0d frame words, %0d register writes",
             checked_cnt, frame_cnt, frame_words, reg_writes);
    $display("Three idle profiles and long output hold-offs were run");
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
